// File: rtl/lslw_pkg.sv
package lslw_pkg;

    localparam int MAX_SLOTS = 4;
    localparam int SLOTS_DEF = 4;

    localparam int W_IN_DATA  = 240;
    localparam int W_OUT_DATA = 352;

    localparam logic [31:0] TICK_LEN_RST  = 32'd24000;
    localparam logic [7:0]  MAX_SLIPS_RST = 8'd4;

    typedef enum logic [0:0] {
        CFG_TICK_LEN  = 1'b0,
        CFG_MAX_SLIPS = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SLIP    = 2'd1,
        STATUS_OVERRUN = 2'd2,
        STATUS_FAULT   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic capture;
        logic mul;
        logic commit;
    } t_cmd;

endpackage

// File: rtl/link_sample_latch_watchdog_core.sv
// Link sample latch and watchdog. One request per control tick enters on the
// s_axis channel; each request yields exactly one result on the m_axis channel.
// A request carries the packet flag, sequence number, sender tick, local receive
// cycle, declared signal count and four sample words. The result carries a
// status code, the held samples and sequence number, the 64-bit skew sum and the
// slip, fault, overrun and gap counters.
// A request passes through three steps: capture, a 32 by 32 multiply of the tick delta by
// the configured tick length, and the update of the watchdog state. No new request
// is accepted until the previous one has made its update. The result is registered
// by the update and sits in the output register until taken; the next request is
// accepted meanwhile, but its update waits until the previous result has left.
// Configuration is written through the plain write port; the user must write it only
// while idle, and the block itself does not enforce this.
// Synchronous reset clears all counters, held words and the skew sum, returns
// the tick length register to 24000 and max_slips to 4, and drops m_axis_tvalid.
module link_sample_latch_watchdog_core #(
    parameter int SLOTS = lslw_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_idx,
    input  logic [31:0]                     i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pkt_seq, pkt_tx_tick, local receive cycle, pkt_signal_count,
    // sample_0 .. sample_3
    input  logic [lslw_pkg::W_IN_DATA-1:0]  s_axis_tdata,
    // have_packet
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // held_0 .. held_3, held_seq, skew_total, total_slip_count, fault_count,
    // overrun_count, gap_count
    output logic [lslw_pkg::W_OUT_DATA-1:0] m_axis_tdata,
    // status
    output logic [1:0]                      m_axis_tuser
);

    lslw_pkg::t_cmd cmd;
    logic [31:0]    samp [lslw_pkg::MAX_SLOTS];
    logic [31:0]    held [lslw_pkg::MAX_SLOTS];
    logic [31:0]    held_seq;
    logic [63:0]    skew;
    logic [31:0]    slip_total;
    logic [31:0]    fault_total;
    logic [31:0]    overrun_total;
    logic [31:0]    gap_total;

    assign samp[0] = s_axis_tdata[143:112];
    assign samp[1] = s_axis_tdata[175:144];
    assign samp[2] = s_axis_tdata[207:176];
    assign samp[3] = s_axis_tdata[239:208];

    lslw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    lslw_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_have          (s_axis_tuser[0]),
        .i_seq           (s_axis_tdata[31:0]),
        .i_tx            (s_axis_tdata[63:32]),
        .i_rx            (s_axis_tdata[95:64]),
        .i_count         (s_axis_tdata[111:96]),
        .i_samp          (samp),
        .o_status        (m_axis_tuser),
        .o_held          (held),
        .o_held_seq      (held_seq),
        .o_skew          (skew),
        .o_slip_total    (slip_total),
        .o_fault_total   (fault_total),
        .o_overrun_total (overrun_total),
        .o_gap_total     (gap_total)
    );

    assign m_axis_tdata = {gap_total, overrun_total, fault_total, slip_total, skew,
                           held_seq, held[3], held[2], held[1], held[0]};

endmodule

// File: rtl/lslw_ctrl.sv
module lslw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lslw_pkg::t_cmd     o_cmd
);

    lslw_pkg::t_state r_state;
    lslw_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lslw_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lslw_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lslw_pkg::ST_MUL;
                end
            end
            lslw_pkg::ST_MUL: begin
                n_state = lslw_pkg::ST_UPD;
            end
            lslw_pkg::ST_UPD: begin
                if (out_free) begin
                    n_state = lslw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lslw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        unique case (r_state)
            lslw_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            lslw_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            lslw_pkg::ST_UPD: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/lslw_dp.sv
module lslw_dp #(
    parameter int SLOTS = lslw_pkg::SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lslw_pkg::t_cmd       i_cmd,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_have,
    input  logic [31:0]          i_seq,
    input  logic [31:0]          i_tx,
    input  logic [31:0]          i_rx,
    input  logic [15:0]          i_count,
    input  logic [31:0]          i_samp [lslw_pkg::MAX_SLOTS],
    output logic [1:0]           o_status,
    output logic [31:0]          o_held [lslw_pkg::MAX_SLOTS],
    output logic [31:0]          o_held_seq,
    output logic [63:0]          o_skew,
    output logic [31:0]          o_slip_total,
    output logic [31:0]          o_fault_total,
    output logic [31:0]          o_overrun_total,
    output logic [31:0]          o_gap_total
);

    localparam int NS = lslw_pkg::MAX_SLOTS;

    logic [31:0] r_cpt;
    logic [7:0]  r_max_slips;

    logic        r_have;
    logic [31:0] r_seq;
    logic [31:0] r_tx;
    logic [31:0] r_rx;
    logic [15:0] r_count;
    logic [31:0] r_samp [NS];

    logic [63:0] r_prod;
    logic        r_tick_zero;
    logic [31:0] r_rx_delta;

    logic [31:0] r_held [NS];
    logic [31:0] r_prev_seq;
    logic [31:0] r_last_rx;
    logic [31:0] r_last_tx;
    logic        r_primed;
    logic [7:0]  r_slip_run;
    logic [31:0] r_slip_total;
    logic [31:0] r_fault_total;
    logic [31:0] r_overrun_total;
    logic [31:0] r_gap_total;
    logic [63:0] r_skew;
    logic [1:0]  r_status;

    logic [7:0]  n_slip_run;
    logic [31:0] n_slip_total;
    logic [31:0] n_fault_total;
    logic [31:0] n_overrun_total;
    logic [31:0] n_gap_total;
    logic [63:0] n_skew;
    logic [1:0]  n_status;
    logic        n_accept;

    logic [31:0] tx_step;
    logic        fresh;
    logic        payload_ok;
    logic [7:0]  run_sat;
    logic [31:0] diff;
    logic [31:0] seq_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpt       <= lslw_pkg::TICK_LEN_RST;
            r_max_slips <= lslw_pkg::MAX_SLIPS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lslw_pkg::CFG_TICK_LEN:  r_cpt       <= i_cfg_data;
                lslw_pkg::CFG_MAX_SLIPS: r_max_slips <= i_cfg_data[7:0];
                default:                 r_cpt       <= r_cpt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_have  <= i_have;
            r_seq   <= i_seq;
            r_tx    <= i_tx;
            r_rx    <= i_rx;
            r_count <= i_count;
            for (int k = 0; k < NS; k++) begin
                r_samp[k] <= i_samp[k];
            end
        end
    end

    assign tx_step = r_tx - r_last_tx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod      <= {32'd0, tx_step} * {32'd0, r_cpt};
            r_tick_zero <= (tx_step == 32'd0);
            r_rx_delta  <= r_rx - r_last_rx;
        end
    end

    always_comb begin
        fresh      = r_have && (!r_primed || (r_seq != r_prev_seq));
        payload_ok = (r_count <= 16'(SLOTS));
        for (int k = 0; k < NS; k++) begin
            if ((k < SLOTS) && (r_samp[k][30:23] == 8'hFF)) begin
                payload_ok = 1'b0;
            end
        end
        run_sat  = (r_slip_run == 8'hFF) ? r_slip_run : r_slip_run + 8'd1;
        diff     = r_rx_delta - r_prod[31:0];
        seq_step = r_seq - r_prev_seq;

        n_slip_run      = r_slip_run;
        n_slip_total    = r_slip_total;
        n_fault_total   = r_fault_total;
        n_overrun_total = r_overrun_total;
        n_gap_total     = r_gap_total;
        n_skew          = r_skew;
        n_status        = lslw_pkg::STATUS_OK;
        n_accept        = 1'b0;

        priority if (!fresh) begin
            n_slip_run   = run_sat;
            n_slip_total = r_slip_total + 32'd1;
            if (run_sat >= r_max_slips) begin
                n_fault_total = r_fault_total + 32'd1;
                n_status      = lslw_pkg::STATUS_FAULT;
            end else begin
                n_status = lslw_pkg::STATUS_SLIP;
            end
        end else if (!payload_ok) begin
            n_fault_total = r_fault_total + 32'd1;
            n_status      = lslw_pkg::STATUS_FAULT;
        end else begin
            n_accept   = 1'b1;
            n_slip_run = 8'd0;
            if (r_primed) begin
                if (!r_tick_zero) begin
                    if (r_prod[63:32] != 32'd0) begin
                        n_gap_total = r_gap_total + 32'd1;
                    end else begin
                        n_skew = r_skew + {{32{diff[31]}}, diff};
                    end
                end
                if (seq_step > 32'd1) begin
                    n_overrun_total = r_overrun_total + 32'd1;
                    n_status        = lslw_pkg::STATUS_OVERRUN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_held[k] <= 32'd0;
            end
            r_prev_seq      <= 32'd0;
            r_last_rx       <= 32'd0;
            r_last_tx       <= 32'd0;
            r_primed        <= 1'b0;
            r_slip_run      <= 8'd0;
            r_slip_total    <= 32'd0;
            r_fault_total   <= 32'd0;
            r_overrun_total <= 32'd0;
            r_gap_total     <= 32'd0;
            r_skew          <= 64'd0;
            r_status        <= lslw_pkg::STATUS_OK;
        end else if (i_cmd.commit) begin
            r_slip_run      <= n_slip_run;
            r_slip_total    <= n_slip_total;
            r_fault_total   <= n_fault_total;
            r_overrun_total <= n_overrun_total;
            r_gap_total     <= n_gap_total;
            r_skew          <= n_skew;
            r_status        <= n_status;
            if (n_accept) begin
                for (int k = 0; k < NS; k++) begin
                    if (k < SLOTS) begin
                        r_held[k] <= r_samp[k];
                    end
                end
                r_prev_seq <= r_seq;
                r_last_rx  <= r_rx;
                r_last_tx  <= r_tx;
                r_primed   <= 1'b1;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            o_held[k] = (k < SLOTS) ? r_held[k] : 32'd0;
        end
    end

    assign o_status        = r_status;
    assign o_held_seq      = r_prev_seq;
    assign o_skew          = r_skew;
    assign o_slip_total    = r_slip_total;
    assign o_fault_total   = r_fault_total;
    assign o_overrun_total = r_overrun_total;
    assign o_gap_total     = r_gap_total;

endmodule

// File: rtl/lslw_checker.sv
module lslw_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [lslw_pkg::W_OUT_DATA-1:0] m_axis_tdata,
    input logic [1:0]                      m_axis_tuser
);

    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not empty after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("request accepted while previous one in flight");

    a_fault_count_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) && (m_axis_tuser == lslw_pkg::STATUS_OK) |->
            $stable(m_axis_tdata[287:256]))
        else $error("fault counter moved on an ok result");

endmodule

bind link_sample_latch_watchdog_core lslw_checker u_lslw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
